/* rtl/core/ctsf_pkg.sv */
// Package for the clock time-setting controller: item types, edit register
// types, action and field codes, limits and reset values.
// No dependencies.
`timescale 1ns / 1ps

package ctsf_pkg;

    // Knob action codes.
    localparam logic [1:0] ACT_FORWARD  = 2'd0;
    localparam logic [1:0] ACT_BACKWARD = 2'd1;
    localparam logic [1:0] ACT_PRESS    = 2'd2;

    // Field select codes.
    localparam logic [2:0] FIELD_YEAR   = 3'd0;
    localparam logic [2:0] FIELD_MONTH  = 3'd1;
    localparam logic [2:0] FIELD_DAY    = 3'd2;
    localparam logic [2:0] FIELD_HOUR   = 3'd3;
    localparam logic [2:0] FIELD_MINUTE = 3'd4;
    localparam logic [2:0] FIELD_SECOND = 3'd5;

    // Field limits.
    localparam logic [7:0] YEAR_MIN   = 8'd70;
    localparam logic [7:0] YEAR_MAX   = 8'd199;
    localparam logic [3:0] MONTH_MAX  = 4'd11;
    localparam logic [4:0] DAY_MIN    = 5'd1;
    localparam logic [4:0] DAY_MAX    = 5'd31;
    localparam logic [4:0] HOUR_MAX   = 5'd23;
    localparam logic [5:0] MINUTE_MAX = 6'd59;
    localparam logic [5:0] SECOND_MAX = 6'd59;

    // Reset contents of the edit registers.
    localparam logic [7:0] RST_YEAR    = 8'd125;
    localparam logic [3:0] RST_MONTH   = 4'd3;
    localparam logic [4:0] RST_DAY     = 5'd30;
    localparam logic [4:0] RST_HOUR    = 5'd12;
    localparam logic [5:0] RST_MINUTE  = 6'd28;
    localparam logic [5:0] RST_SECOND  = 6'd0;
    localparam logic [2:0] RST_WEEKDAY = 3'd3;

    typedef enum logic {
        MODE_NORMAL  = 1'b0,
        MODE_SETTING = 1'b1
    } mode_t;

    typedef struct packed {
        logic [1:0] action;
        logic [7:0] live_year;
        logic [3:0] live_month;
        logic [4:0] live_day;
        logic [4:0] live_hour;
        logic [5:0] live_minute;
        logic [5:0] live_second;
        logic [2:0] live_weekday;
    } knob_item_t;

    typedef struct packed {
        logic       in_setting;
        logic [2:0] selected_field;
        logic [7:0] edit_year;
        logic [3:0] edit_month;
        logic [4:0] edit_day;
        logic [4:0] edit_hour;
        logic [5:0] edit_minute;
        logic [5:0] edit_second;
        logic [2:0] edit_weekday;
        logic       commit;
    } result_item_t;

    typedef struct packed {
        logic [7:0] year;
        logic [3:0] month;
        logic [4:0] day;
        logic [4:0] hour;
        logic [5:0] minute;
        logic [5:0] second;
        logic [2:0] weekday;
    } edit_t;

    // Mode and field select, the control state of the controller.
    typedef struct packed {
        mode_t      mode;
        logic [2:0] field;
    } ctl_t;

endpackage

/* rtl/core/ctsf_step.sv */
// Next-state logic of the time-setting controller for one knob item.
// Depends on ctsf_pkg.
`timescale 1ns / 1ps

module ctsf_step
    import ctsf_pkg::*;
(
    input  knob_item_t knob,
    input  ctl_t       ctl,
    input  edit_t      edit,
    output ctl_t       ctl_next,
    output edit_t      edit_next,
    output logic       commit
);

    logic press;
    logic step_en;
    logic up;
    logic last_field;

    assign press      = (knob.action == ACT_PRESS);
    assign up         = (knob.action == ACT_FORWARD);
    assign step_en    = (ctl.mode == MODE_SETTING) &&
                        ((knob.action == ACT_FORWARD) || (knob.action == ACT_BACKWARD));
    assign last_field = (ctl.field >= FIELD_SECOND);

    // Next mode.
    always_comb
    begin
        ctl_next.mode = ctl.mode;
        if (press)
        begin
            case (ctl.mode)
                MODE_NORMAL:  ctl_next.mode = MODE_SETTING;
                MODE_SETTING: ctl_next.mode = last_field ? MODE_NORMAL : MODE_SETTING;
                default:      ctl_next.mode = MODE_NORMAL;
            endcase
        end
    end

    // Field select and commit flag.
    always_comb
    begin
        ctl_next.field = ctl.field;
        commit         = 1'b0;
        if (press)
        begin
            if (ctl.mode == MODE_NORMAL)
            begin
                ctl_next.field = FIELD_YEAR;
            end
            else if (last_field)
            begin
                ctl_next.field = FIELD_YEAR;
                commit         = 1'b1;
            end
            else
            begin
                ctl_next.field = ctl.field + 3'd1;
            end
        end
    end

    // Edit registers: load on entry, step the selected field in setting mode.
    always_comb
    begin
        edit_next = edit;
        if (press && (ctl.mode == MODE_NORMAL))
        begin
            edit_next.year    = knob.live_year;
            edit_next.month   = knob.live_month;
            edit_next.day     = knob.live_day;
            edit_next.hour    = knob.live_hour;
            edit_next.minute  = knob.live_minute;
            edit_next.second  = knob.live_second;
            edit_next.weekday = knob.live_weekday;
        end
        else if (step_en)
        begin
            case (ctl.field)
                FIELD_YEAR:
                begin
                    if (up)
                        edit_next.year = (edit.year >= YEAR_MAX) ? YEAR_MAX
                                                                 : edit.year + 8'd1;
                    else
                        edit_next.year = (edit.year <= YEAR_MIN) ? YEAR_MIN
                                                                 : edit.year - 8'd1;
                end
                FIELD_MONTH:
                begin
                    if (up)
                        edit_next.month = (edit.month >= MONTH_MAX) ? 4'd0
                                                                    : edit.month + 4'd1;
                    else
                        edit_next.month = ((edit.month == 4'd0) || (edit.month > MONTH_MAX))
                                          ? MONTH_MAX : edit.month - 4'd1;
                end
                FIELD_DAY:
                begin
                    if (up)
                        edit_next.day = ((edit.day >= DAY_MAX) || (edit.day < DAY_MIN))
                                        ? DAY_MIN : edit.day + 5'd1;
                    else
                        edit_next.day = (edit.day <= DAY_MIN) ? DAY_MAX : edit.day - 5'd1;
                end
                FIELD_HOUR:
                begin
                    if (up)
                        edit_next.hour = (edit.hour >= HOUR_MAX) ? 5'd0 : edit.hour + 5'd1;
                    else
                        edit_next.hour = ((edit.hour == 5'd0) || (edit.hour > HOUR_MAX))
                                         ? HOUR_MAX : edit.hour - 5'd1;
                end
                FIELD_MINUTE:
                begin
                    if (up)
                        edit_next.minute = (edit.minute >= MINUTE_MAX) ? 6'd0
                                                                       : edit.minute + 6'd1;
                    else
                        edit_next.minute = ((edit.minute == 6'd0) || (edit.minute > MINUTE_MAX))
                                           ? MINUTE_MAX : edit.minute - 6'd1;
                end
                FIELD_SECOND:
                begin
                    if (up)
                        edit_next.second = (edit.second >= SECOND_MAX) ? 6'd0
                                                                       : edit.second + 6'd1;
                    else
                        edit_next.second = ((edit.second == 6'd0) || (edit.second > SECOND_MAX))
                                           ? SECOND_MAX : edit.second - 6'd1;
                end
                default:
                begin
                    edit_next = edit;
                end
            endcase
        end
    end

endmodule

/* rtl/core/clock_time_setting_fsm.sv */
// A knob item accepted into the input register moves on to the result
// register and is presented on the result port. One item per cycle while
// the result stage is not stalled by result_ready; an input register and a
// result register set the two-stage pipeline, the state update between them.
// Reset (rst_n low, asynchronous): normal mode, year field selected, edit
// registers at their power-up time, both pipeline stages empty.
// Depends on ctsf_pkg and ctsf_step.
`timescale 1ns / 1ps

module clock_time_setting_fsm
    import ctsf_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         knob_valid,
    output logic         knob_ready,
    input  knob_item_t   knob,
    output logic         result_valid,
    input  logic         result_ready,
    output result_item_t result
);

    // Input stage: holds one accepted knob item.
    logic       knob_valid_reg;
    knob_item_t knob_reg;

    // Controller state and result stage.
    ctl_t         ctl_reg;
    edit_t        edit_reg;
    logic         result_valid_reg;
    result_item_t result_reg;

    ctl_t  ctl_next;
    edit_t edit_next;
    logic  commit_next;
    logic  advance;

    // The held item moves into the result stage whenever that stage is empty
    // or its item is being taken in this cycle. The controller state changes
    // only on that move, so each item sees the state its predecessor left.
    assign advance    = knob_valid_reg && (!result_valid_reg || result_ready);
    assign knob_ready = !knob_valid_reg || advance;

    ctsf_step u_step (
        .knob      (knob_reg),
        .ctl       (ctl_reg),
        .edit      (edit_reg),
        .ctl_next  (ctl_next),
        .edit_next (edit_next),
        .commit    (commit_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            knob_valid_reg <= 1'b0;
        end
        else if (knob_ready)
        begin
            knob_valid_reg <= knob_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (knob_valid && knob_ready)
        begin
            knob_reg <= knob;
        end
    end

    // Control state and the edit registers carry visible reset values.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl_reg.mode     <= MODE_NORMAL;
            ctl_reg.field    <= FIELD_YEAR;
            edit_reg.year    <= RST_YEAR;
            edit_reg.month   <= RST_MONTH;
            edit_reg.day     <= RST_DAY;
            edit_reg.hour    <= RST_HOUR;
            edit_reg.minute  <= RST_MINUTE;
            edit_reg.second  <= RST_SECOND;
            edit_reg.weekday <= RST_WEEKDAY;
        end
        else if (advance)
        begin
            ctl_reg  <= ctl_next;
            edit_reg <= edit_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            result_valid_reg <= 1'b1;
        end
        else if (result_ready)
        begin
            result_valid_reg <= 1'b0;
        end
    end

    // The result reflects the state after the item is applied. The field
    // select is back at year whenever the block is in normal mode.
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            result_reg.in_setting     <= (ctl_next.mode == MODE_SETTING);
            result_reg.selected_field <= (ctl_next.mode == MODE_SETTING) ? ctl_next.field
                                                                         : FIELD_YEAR;
            result_reg.edit_year      <= edit_next.year;
            result_reg.edit_month     <= edit_next.month;
            result_reg.edit_day       <= edit_next.day;
            result_reg.edit_hour      <= edit_next.hour;
            result_reg.edit_minute    <= edit_next.minute;
            result_reg.edit_second    <= edit_next.second;
            result_reg.edit_weekday   <= edit_next.weekday;
            result_reg.commit         <= commit_next;
        end
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    // A commit always closes setting mode.
    a_commit_leaves: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid_reg && result_reg.commit) |->
            (!result_reg.in_setting && (result_reg.selected_field == FIELD_YEAR)))
        else $error("commit result still shows setting mode");

    // Normal mode keeps the year field selected.
    a_normal_field: assert property (@(posedge clk) disable iff (!rst_n)
        (ctl_reg.mode == MODE_NORMAL) |-> (ctl_reg.field == FIELD_YEAR))
        else $error("field select not at year in normal mode");

    // Field select never runs past the second field.
    a_field_range: assert property (@(posedge clk) disable iff (!rst_n)
        ctl_reg.field <= FIELD_SECOND)
        else $error("field select out of range");

    // An item that moves into the result stage is presented next cycle.
    a_advance_shows: assert property (@(posedge clk) disable iff (!rst_n)
        advance |=> result_valid_reg)
        else $error("advanced item not presented");

    // Commit is raised only by a press made in setting mode.
    a_commit_from_setting: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && commit_next) |-> (ctl_reg.mode == MODE_SETTING))
        else $error("commit raised outside setting mode");

endmodule
